// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared widths, lane commands and status types of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int ReqW   = 16;
  localparam int NumW   = 17;
  localparam int PosW   = 11;
  localparam int TagW   = 16;
  localparam int StoreW = 2;
  localparam int StartW = 6;
  localparam int CountW = 7;
  localparam int OffW   = 14;
  localparam int GrantW = 15;

  typedef enum logic [1:0] {
    LOP_IDLE,
    LOP_SCAN,
    LOP_SET,
    LOP_CLEAR
  } lane_op_e;

  typedef struct packed {
    lane_op_e          op;
    logic [PosW-1:0]   pos;
    logic [PosW-1:0]   need;
    logic [PosW-1:0]   lo;
    logic [PosW-1:0]   hi;
  } lane_cmd_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] start;
  } lane_stat_t;

  typedef struct packed {
    logic            done;
    logic [NumW-1:0] need;
  } div_res_t;

endpackage

// ===== sv/ffa_div.sv =====
// ----------------------------------------------------------------------------
// ffa_div
// Bit-serial restoring divider giving the number of blocks for a byte count.
// ----------------------------------------------------------------------------
module ffa_div #(
  parameter int BLOCK_BYTES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ffa_pkg::ReqW-1:0]   bytes_i,
  output ffa_pkg::div_res_t          res_o
);
  import ffa_pkg::*;

  localparam logic [4:0]    Steps = 5'(NumW);
  localparam logic [NumW:0] Dvs   = (NumW + 1)'(BLOCK_BYTES);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [4:0]      cnt_q;
  logic            busy_q, done_q, zero_q;
  logic [NumW:0]   rem_sh;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, num_q[NumW-1]};
    ge     = rem_sh >= Dvs;
    rem_d  = ge ? NumW'(rem_sh - Dvs) : NumW'(rem_sh);
    num_d  = {num_q[NumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= Steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= NumW'(bytes_i) + NumW'(BLOCK_BYTES - 1);
      rem_q  <= '0;
      zero_q <= (bytes_i == '0);
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.need = zero_q ? NumW'(1) : num_q;

endmodule

// ===== sv/ffa_lane.sv =====
// ----------------------------------------------------------------------------
// ffa_lane
// One store's free bitmap as a rotating shift register with its run finder.
// ----------------------------------------------------------------------------
module ffa_lane #(
  parameter int BLOCKS_PER_STORE = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  ffa_pkg::lane_cmd_t     cmd_i,
  output ffa_pkg::lane_stat_t    stat_o
);
  import ffa_pkg::*;

  localparam int BW = $clog2(BLOCKS_PER_STORE);
  localparam int CW = $clog2(BLOCKS_PER_STORE + 1);

  logic [BLOCKS_PER_STORE-1:0] map_q, map_d;
  logic [CW-1:0]               run_q, run_d, run_base, run_inc;
  logic                        found_q, found_d, found_base;
  logic [BW-1:0]               start_q, start_d;
  logic                        cur, new_bit, in_range;

  always_comb begin
    cur        = map_q[0];
    new_bit    = cur;
    in_range   = (cmd_i.pos >= cmd_i.lo) && (cmd_i.pos < cmd_i.hi);
    run_base   = (cmd_i.pos == '0) ? '0 : run_q;
    found_base = (cmd_i.pos == '0) ? 1'b0 : found_q;
    run_inc    = run_base + CW'(1);
    run_d      = run_q;
    found_d    = found_q;
    start_d    = start_q;
    unique case (cmd_i.op)
      LOP_SCAN: begin
        if (en_i) begin
          run_d   = run_base;
          found_d = found_base;
          if (!found_base) begin
            if (cur) begin
              run_d = run_inc;
              if (PosW'(run_inc) >= cmd_i.need) begin
                found_d = 1'b1;
                start_d = BW'(cmd_i.pos - PosW'(run_base));
              end
            end else begin
              run_d = '0;
            end
          end
        end
      end
      LOP_SET: begin
        if (en_i && in_range) begin
          new_bit = 1'b1;
        end
      end
      LOP_CLEAR: begin
        if (en_i && in_range) begin
          new_bit = 1'b0;
        end
      end
      default: begin
      end
    endcase
    map_d = (cmd_i.op == LOP_IDLE) ? map_q : {new_bit, map_q[BLOCKS_PER_STORE-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '1;
      run_q   <= '0;
      found_q <= 1'b0;
    end else begin
      map_q   <= map_d;
      run_q   <= run_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

  assign stat_o.found = found_q;
  assign stat_o.start = PosW'(start_q);

endmodule

// ===== sv/first_fit_block_run_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_run_allocator_core
// First-fit allocator of block runs over a set of stores with free bitmaps.
// ----------------------------------------------------------------------------
// Each store keeps its free bitmap in a shift register that turns one block
// per cycle while it is scanned, marked or freed, and all stores are searched
// side by side in one turn. An allocate beat runs the bit-serial division of
// the byte count, one turn of the bitmaps to find the first fitting run in
// every store, a step to choose the store, a second turn to mark the run used
// and tag its blocks, and a step to load the result. A request that cannot fit
// in one store returns after the division without a turn, and a free beat
// takes one turn of the bitmaps and a step to load the result. One request is
// worked on at a time; the next request is taken while a result still waits
// in the output register.
module first_fit_block_run_allocator_core #(
  parameter int BLOCK_BYTES      = 256,
  parameter int BLOCKS_PER_STORE = 64,
  parameter int STORES           = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [ffa_pkg::ReqW-1:0]      request_bytes_i,
  input  logic [ffa_pkg::StoreW-1:0]    free_store_i,
  input  logic [ffa_pkg::StartW-1:0]    free_start_i,
  input  logic [ffa_pkg::CountW-1:0]    free_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          ok_o,
  output logic [ffa_pkg::StoreW-1:0]    store_index_o,
  output logic [ffa_pkg::StartW-1:0]    start_block_o,
  output logic [ffa_pkg::CountW-1:0]    block_count_o,
  output logic [ffa_pkg::OffW-1:0]      byte_offset_o,
  output logic [ffa_pkg::GrantW-1:0]    granted_bytes_o,
  output logic [ffa_pkg::TagW-1:0]      chain_tag_o
);
  import ffa_pkg::*;

  localparam int BW       = $clog2(BLOCKS_PER_STORE);
  localparam int CW       = $clog2(BLOCKS_PER_STORE + 1);
  localparam int SW       = (STORES > 1) ? $clog2(STORES) : 1;
  localparam int AcW      = $clog2(STORES + 1);
  localparam int OwnDepth = STORES * BLOCKS_PER_STORE;
  localparam int OwnAW    = $clog2(OwnDepth);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StPick = 3'd3;
  localparam logic [2:0] StMark = 3'd4;
  localparam logic [2:0] StFree = 3'd5;
  localparam logic [2:0] StDone = 3'd6;

  logic [2:0]         state_q;
  logic [BW-1:0]      pos_q;
  logic               pos_last;
  logic [StoreW-1:0]  fstore_q;
  logic [StartW-1:0]  fstart_q;
  logic [CountW-1:0]  fcount_q;
  logic [CW-1:0]      need_q;
  logic [SW-1:0]      sel_q;
  logic [BW-1:0]      st_q;
  logic [TagW-1:0]    tag_q;
  logic [TagW-1:0]    chain_q [STORES];
  logic [AcW-1:0]     active_q;
  logic               res_ok_q, res_grant_q;
  logic               out_valid_q;
  logic               in_fire, load_out;
  logic               fstore_ok;

  logic [TagW-1:0]    owner_q [OwnDepth];
  logic [OwnAW-1:0]   own_addr;
  logic               own_in_range;

  div_res_t           div_res;
  lane_cmd_t          lane_cmd;
  lane_stat_t         lane_stat [STORES];
  logic [STORES-1:0]  lane_en;
  logic               pick_hit;
  logic [SW-1:0]      pick_s;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_last   = (pos_q == BW'(BLOCKS_PER_STORE - 1));
  assign fstore_ok  = 5'(fstore_q) < 5'(active_q);
  assign load_out   = (state_q == StDone) && (!out_valid_q || out_ready_i);

  ffa_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_fire && !mode_i),
    .bytes_i(request_bytes_i),
    .res_o  (div_res)
  );

  always_comb begin
    lane_cmd.op   = LOP_IDLE;
    lane_cmd.pos  = PosW'(pos_q);
    lane_cmd.need = PosW'(need_q);
    lane_cmd.lo   = '0;
    lane_cmd.hi   = '0;
    lane_en       = '0;
    unique case (state_q)
      StScan: begin
        lane_cmd.op = LOP_SCAN;
        lane_en     = '1;
      end
      StMark: begin
        lane_cmd.op = LOP_CLEAR;
        lane_cmd.lo = PosW'(st_q);
        lane_cmd.hi = PosW'(st_q) + PosW'(need_q);
        for (int i = 0; i < STORES; i++) begin
          lane_en[i] = (SW'(i) == sel_q);
        end
      end
      StFree: begin
        lane_cmd.op = LOP_SET;
        lane_cmd.lo = PosW'(fstart_q);
        lane_cmd.hi = PosW'(fstart_q) + PosW'(fcount_q);
        for (int i = 0; i < STORES; i++) begin
          lane_en[i] = (5'(i) == 5'(fstore_q)) && fstore_ok;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < STORES; g++) begin : g_lane
    ffa_lane #(
      .BLOCKS_PER_STORE(BLOCKS_PER_STORE)
    ) u_lane (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (lane_en[g]),
      .cmd_i (lane_cmd),
      .stat_o(lane_stat[g])
    );
  end

  // The store just past the active ones is always wholly free, so it takes
  // part in the choice as the store that would be brought into use.
  always_comb begin
    pick_hit = 1'b0;
    pick_s   = '0;
    for (int i = STORES - 1; i >= 0; i--) begin
      if (lane_stat[i].found && (AcW'(i) <= active_q)) begin
        pick_hit = 1'b1;
        pick_s   = SW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      active_q    <= AcW'(1);
      res_ok_q    <= 1'b0;
      res_grant_q <= 1'b0;
      for (int i = 0; i < STORES; i++) begin
        chain_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            state_q <= mode_i ? StFree : StDiv;
          end
        end
        StDiv: begin
          if (div_res.done) begin
            if (div_res.need > NumW'(BLOCKS_PER_STORE)) begin
              res_ok_q    <= 1'b0;
              res_grant_q <= 1'b0;
              state_q     <= StDone;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          pos_q <= pos_last ? '0 : pos_q + BW'(1);
          if (pos_last) begin
            state_q <= StPick;
          end
        end
        StPick: begin
          if (pick_hit) begin
            chain_q[pick_s] <= chain_q[pick_s] + TagW'(1);
            if (AcW'(pick_s) == active_q) begin
              active_q <= active_q + AcW'(1);
            end
            state_q <= StMark;
          end else begin
            res_ok_q    <= 1'b0;
            res_grant_q <= 1'b0;
            state_q     <= StDone;
          end
        end
        StMark: begin
          pos_q <= pos_last ? '0 : pos_q + BW'(1);
          if (pos_last) begin
            res_ok_q    <= 1'b1;
            res_grant_q <= 1'b1;
            state_q     <= StDone;
          end
        end
        StFree: begin
          pos_q <= pos_last ? '0 : pos_q + BW'(1);
          if (pos_last) begin
            res_ok_q    <= 1'b1;
            res_grant_q <= 1'b0;
            state_q     <= StDone;
          end
        end
        StDone: begin
          if (load_out) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fstore_q <= free_store_i;
      fstart_q <= free_start_i;
      fcount_q <= free_count_i;
    end
    if ((state_q == StDiv) && div_res.done) begin
      need_q <= CW'(div_res.need);
    end
    if ((state_q == StPick) && pick_hit) begin
      sel_q <= pick_s;
      st_q  <= BW'(lane_stat[pick_s].start);
      tag_q <= chain_q[pick_s];
    end
  end

  assign own_in_range = (lane_cmd.pos >= lane_cmd.lo) && (lane_cmd.pos < lane_cmd.hi);
  assign own_addr     = OwnAW'(sel_q) * OwnAW'(BLOCKS_PER_STORE) + OwnAW'(pos_q);

  always_ff @(posedge clk_i) begin
    if ((state_q == StMark) && own_in_range) begin
      owner_q[own_addr] <= tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ok_o <= res_ok_q;
      if (res_grant_q) begin
        store_index_o   <= StoreW'(sel_q);
        start_block_o   <= StartW'(st_q);
        block_count_o   <= CountW'(need_q);
        byte_offset_o   <= OffW'(OffW'(st_q) * OffW'(BLOCK_BYTES));
        granted_bytes_o <= GrantW'(GrantW'(need_q) * GrantW'(BLOCK_BYTES));
        chain_tag_o     <= tag_q;
      end else begin
        store_index_o   <= '0;
        start_block_o   <= '0;
        block_count_o   <= '0;
        byte_offset_o   <= '0;
        granted_bytes_o <= '0;
        chain_tag_o     <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
